// ===== hw/rtl/orb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orb_pkg: shared types and constants of the overwriting ring buffer
// Sizes, item and result layouts, operation codes and wrap helpers.
// ----------------------------------------------------------------------------
package orb_pkg;

  localparam int DEPTH      = 32;
  localparam int VALUE_BITS = 32;

  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int SUM_W   = IDX_W + 1;
  localparam int CFG_W   = 6;
  localparam int COUNT_W = 6;

  localparam int IN_TDATA_W  = ((VALUE_BITS + 7) / 8) * 8;
  localparam int OUT_RAW_W   = 2 * VALUE_BITS + 2 + COUNT_W;
  localparam int OUT_TDATA_W = ((OUT_RAW_W + 7) / 8) * 8;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic OP_INSERT   = 1'b0;
  localparam logic OP_DUMP     = 1'b1;
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_DUMP   = 1'b1;

  typedef struct packed {
    logic                  is_dump;
    logic [VALUE_BITS-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic                  kind;
    logic                  evicted_valid;
    logic [VALUE_BITS-1:0] evicted_value;
    logic [VALUE_BITS-1:0] element_value;
    logic                  element_valid;
    logic [COUNT_W-1:0]    entry_count;
    logic                  last;
  } result_t;

  // Zero reads as one, anything above the storage depth saturates.
  function automatic logic [CNT_W-1:0] eff_capacity(input logic [CFG_W-1:0] v);
    logic [CNT_W-1:0] c;
    if (v == '0) begin
      c = CNT_W'(1);
    end else if (int'(v) > DEPTH) begin
      c = CNT_W'(DEPTH);
    end else begin
      c = CNT_W'(v);
    end
    return c;
  endfunction

  // Advance a position by one, wrapping at the capacity.
  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] pos,
                                                 input logic [CNT_W-1:0] cap);
    logic [SUM_W-1:0] s;
    s = SUM_W'(pos) + SUM_W'(1);
    return (s == SUM_W'(cap)) ? '0 : s[IDX_W-1:0];
  endfunction

  localparam logic [CNT_W-1:0] CAP_RESET = eff_capacity(CFG_W'(32));

endpackage

// ===== hw/rtl/overwriting_ring_buffer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overwriting_ring_buffer_unit: overwriting circular history buffer
// Stores the most recent values up to a set capacity and dumps them on request.
// ----------------------------------------------------------------------------
// Requests enter on the in_ stream: tuser selects insert (0) or dump (1),
// tdata carries the value to insert. Results leave on the out_ stream, one
// per insert and one per stored entry on a dump (a single empty marker when
// nothing is stored), with tlast on the final result of each request.
// cfg_wr_en with cfg_wdata sets the capacity and empties the buffer; write it
// only while no request is in flight.
// Path: a request passes the intake register and the queue; the engine then
// registers its result, for an evicting insert and a dump after an RAM read.
// Throughput: appending inserts run at one per cycle while results are taken;
// an evicting insert reads before writing, as the single read port fetches the
// old entry first; a dump reads the RAM once per entry before the next request.
// Reset empties the buffer and restores a capacity of 32. The RAM needs no
// clearing pass, as only written entries are ever read. When the receiver
// stalls, the result is held in the output register and the intake keeps
// taking requests until the two-entry queue and the intake register fill up.
// ----------------------------------------------------------------------------
module overwriting_ring_buffer_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [orb_pkg::IN_TDATA_W-1:0]    in_tdata,   // [31:0] new_value
  input  logic                              in_tuser,   // [0] operation
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [0] evicted_valid, [32:1] evicted_value, [64:33] element_value,
  // [65] element_valid, [71:66] entry_count
  output logic [orb_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                              out_tuser,  // [0] result_kind
  output logic                              out_tlast,
  input  logic                              cfg_wr_en,
  input  logic [orb_pkg::CFG_W-1:0]         cfg_wdata
);
  import orb_pkg::*;

  logic    push_valid;
  logic    push_ready;
  cmd_t    push_cmd;
  logic    pop_valid;
  logic    pop_ready;
  cmd_t    pop_cmd;
  result_t res;

  orb_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_op      (in_tuser),
    .in_value   (in_tdata[VALUE_BITS-1:0]),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  orb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  orb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_wdata (cfg_wdata),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = OUT_TDATA_W'({res.entry_count, res.element_valid, res.element_value,
                                   res.evicted_value, res.evicted_valid});
  assign out_tuser = res.kind;
  assign out_tlast = res.last;

endmodule

// ===== hw/rtl/orb_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orb_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module orb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic                                    rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/orb_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orb_front: request intake
// Registers each request, decodes the operation and hands it to the queue.
// ----------------------------------------------------------------------------
module orb_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_op,
  input  logic [orb_pkg::VALUE_BITS-1:0]  in_value,
  output logic                            push_valid,
  input  logic                            push_ready,
  output orb_pkg::cmd_t                   push_cmd
);
  import orb_pkg::*;

  logic hold_valid_r;
  logic hold_valid_nxt;
  cmd_t hold_cmd_r;
  cmd_t hold_cmd_nxt;

  assign in_ready = !hold_valid_r || push_ready;

  always_comb begin
    hold_valid_nxt = hold_valid_r && !push_ready;
    hold_cmd_nxt   = hold_cmd_r;
    if (in_valid && in_ready) begin
      hold_valid_nxt       = 1'b1;
      hold_cmd_nxt.is_dump = (in_op == OP_DUMP);
      hold_cmd_nxt.value   = in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
    hold_cmd_r <= hold_cmd_nxt;
  end

  assign push_valid = hold_valid_r;
  assign push_cmd   = hold_cmd_r;

endmodule

// ===== hw/rtl/orb_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orb_queue: short command queue
// Small FIFO between intake and execution so either side can stall alone.
// ----------------------------------------------------------------------------
module orb_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  orb_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop_ready,
  output orb_pkg::cmd_t pop_cmd
);
  import orb_pkg::*;

  cmd_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= QPTR_W'(wr_ptr_r + 1'b1);
      end
      if (do_pop) begin
        rd_ptr_r <= QPTR_W'(rd_ptr_r + 1'b1);
      end
      if (do_push && !do_pop) begin
        count_r <= QCNT_W'(count_r + 1'b1);
      end else if (do_pop && !do_push) begin
        count_r <= QCNT_W'(count_r - 1'b1);
      end
    end
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== hw/rtl/orb_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orb_back: execution engine
// Keeps fill level and oldest position, runs inserts and dumps on the RAM.
// ----------------------------------------------------------------------------
module orb_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [orb_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                       pop_valid,
  output logic                       pop_ready,
  input  orb_pkg::cmd_t              pop_cmd,
  output logic                       out_valid,
  input  logic                       out_ready,
  output orb_pkg::result_t           out_res
);
  import orb_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_EVICT, ST_DUMP} state_t;

  state_t                state_r,  state_nxt;
  logic [CNT_W-1:0]      cap_r,    cap_nxt;
  logic [CNT_W-1:0]      fill_r,   fill_nxt;
  logic [IDX_W-1:0]      oldest_r, oldest_nxt;
  logic [IDX_W-1:0]      pos_r,    pos_nxt;
  logic [CNT_W-1:0]      left_r,   left_nxt;
  logic [VALUE_BITS-1:0] val_r,    val_nxt;
  logic                  out_valid_r, out_valid_nxt;
  result_t               res_r,    res_nxt;

  logic                  slot_free;
  logic [SUM_W-1:0]      app_sum;
  logic [SUM_W-1:0]      app_wrap;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [VALUE_BITS-1:0] wr_data;
  logic                  rd_en;
  logic [IDX_W-1:0]      rd_addr;
  logic [VALUE_BITS-1:0] rd_data;

  orb_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign slot_free = !out_valid_r || out_ready;
  // Oldest is below capacity and fill at most capacity, so one subtract wraps the sum.
  assign app_sum   = SUM_W'(oldest_r) + SUM_W'(fill_r);
  assign app_wrap  = (app_sum >= SUM_W'(cap_r)) ? app_sum - SUM_W'(cap_r) : app_sum;

  always_comb begin
    state_nxt     = state_r;
    cap_nxt       = cap_r;
    fill_nxt      = fill_r;
    oldest_nxt    = oldest_r;
    pos_nxt       = pos_r;
    left_nxt      = left_r;
    val_nxt       = val_r;
    out_valid_nxt = out_valid_r && !out_ready;
    res_nxt       = res_r;
    pop_ready     = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = oldest_r;
    wr_data       = val_r;
    rd_en         = 1'b0;
    rd_addr       = oldest_r;

    unique case (state_r)
      ST_IDLE: begin
        if (pop_valid && slot_free) begin
          pop_ready = 1'b1;
          if (!pop_cmd.is_dump) begin
            if (fill_r < cap_r) begin
              wr_en         = 1'b1;
              wr_addr       = app_wrap[IDX_W-1:0];
              wr_data       = pop_cmd.value;
              fill_nxt      = CNT_W'(fill_r + 1'b1);
              out_valid_nxt = 1'b1;
              res_nxt       = '{kind: KIND_INSERT, evicted_valid: 1'b0,
                                evicted_value: '0, element_value: '0,
                                element_valid: 1'b0,
                                entry_count: COUNT_W'(fill_r + 1'b1), last: 1'b1};
            end else begin
              // Full: fetch the oldest entry before overwriting it.
              rd_en     = 1'b1;
              val_nxt   = pop_cmd.value;
              state_nxt = ST_EVICT;
            end
          end else if (fill_r == '0) begin
            out_valid_nxt = 1'b1;
            res_nxt       = '{kind: KIND_DUMP, evicted_valid: 1'b0,
                              evicted_value: '0, element_value: '0,
                              element_valid: 1'b0, entry_count: '0, last: 1'b1};
          end else begin
            rd_en     = 1'b1;
            pos_nxt   = wrap_inc(oldest_r, cap_r);
            left_nxt  = CNT_W'(fill_r - 1'b1);
            state_nxt = ST_DUMP;
          end
        end
      end

      ST_EVICT: begin
        if (slot_free) begin
          wr_en         = 1'b1;
          oldest_nxt    = wrap_inc(oldest_r, cap_r);
          out_valid_nxt = 1'b1;
          res_nxt       = '{kind: KIND_INSERT, evicted_valid: 1'b1,
                            evicted_value: rd_data, element_value: '0,
                            element_valid: 1'b0,
                            entry_count: COUNT_W'(fill_r), last: 1'b1};
          state_nxt     = ST_IDLE;
        end
      end

      ST_DUMP: begin
        // Emit the fetched entry and fetch the next one in the same cycle.
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          res_nxt       = '{kind: KIND_DUMP, evicted_valid: 1'b0,
                            evicted_value: '0, element_value: rd_data,
                            element_valid: 1'b1,
                            entry_count: COUNT_W'(fill_r), last: (left_r == '0)};
          if (left_r != '0) begin
            rd_en    = 1'b1;
            rd_addr  = pos_r;
            pos_nxt  = wrap_inc(pos_r, cap_r);
            left_nxt = CNT_W'(left_r - 1'b1);
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // A capacity change empties the buffer.
    if (cfg_wr_en) begin
      cap_nxt    = eff_capacity(cfg_wdata);
      fill_nxt   = '0;
      oldest_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cap_r       <= CAP_RESET;
      fill_r      <= '0;
      oldest_r    <= '0;
      pos_r       <= '0;
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cap_r       <= cap_nxt;
      fill_r      <= fill_nxt;
      oldest_r    <= oldest_nxt;
      pos_r       <= pos_nxt;
      left_r      <= left_nxt;
      out_valid_r <= out_valid_nxt;
    end
    val_r <= val_nxt;
    res_r <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= cap_r)
    else $error("fill level above capacity");

  a_oldest_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    CNT_W'(oldest_r) < cap_r)
    else $error("oldest position outside capacity");

  a_evict_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EVICT) |-> (fill_r == cap_r))
    else $error("eviction while buffer not full");

  a_dump_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DUMP) |-> (fill_r != '0) && (left_r < fill_r))
    else $error("dump walk on empty buffer or beyond fill level");

endmodule
